// ----- design/drt_pkg.sv -----
// shared types, codes and constants of the dirty rectangle tracker
`default_nettype none
package drt_pkg;

	localparam int DRT_MAX_RECTS = 32;
	localparam int DRT_MAX_SIDE  = 4096;
	localparam int DRT_OUT_W     = 13;
	localparam int DRT_CNT_W     = 7;
	localparam int DRT_CLIP_W    = 18;

	localparam logic [12:0] DRT_RST_WIDTH    = 13'd320;
	localparam logic [12:0] DRT_RST_HEIGHT   = 13'd200;
	localparam logic [7:0]  DRT_RST_DISTANCE = 8'd16;
	localparam logic [5:0]  DRT_RST_LIMIT    = 6'd4;
	localparam logic [3:0]  DRT_RST_PASSES   = 4'd5;

	localparam logic [2:0] REG_WINDOW_WIDTH   = 3'd0;
	localparam logic [2:0] REG_WINDOW_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_MERGE_DISTANCE = 3'd2;
	localparam logic [2:0] REG_DIRECT_LIMIT   = 3'd3;
	localparam logic [2:0] REG_MERGE_PASSES   = 3'd4;

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_DIRTY   = 3'd1,
		CMD_BEGIN   = 3'd2,
		CMD_MERGE   = 3'd3,
		CMD_PRESENT = 3'd4,
		CMD_FORCE   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_NONE = 2'd1,
		KIND_RECT = 2'd2,
		KIND_FULL = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LATCH,
		OP_CLIP,
		OP_ADD,
		OP_DIRTY,
		OP_BEGIN,
		OP_FORCE,
		OP_MINIT,
		OP_PASS,
		OP_LDA,
		OP_CMP,
		OP_MOVE,
		OP_ENDI,
		OP_PRES,
		OP_RDK,
		OP_ORECT,
		OP_RESP
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_ADD,
		ST_MPASS,
		ST_MLDA,
		ST_MCMP,
		ST_MMOVE,
		ST_MENDI,
		ST_MPEND,
		ST_PRD,
		ST_PRECT,
		ST_RESP
	} state_t;

	typedef struct packed {
		dp_op_t op;
		kind_t  kind;
		logic   in_ready;
	} ctrl_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic                 dirty;
		logic                 cnt_le1;
		logic                 near;
		logic                 j_last;
		logic                 j_next_ok;
		logic                 i_more;
		logic                 pass_again;
		logic                 partial;
		logic                 k_last;
		logic                 out_free;
		logic [DRT_CNT_W-1:0] cnt;
	} status_t;

endpackage
`default_nettype wire

// ----- design/dirty_rect_tracker_unit.sv -----
// top level of the dirty rectangle tracker
// add beat: latch, clip, add, result; other beats with one result: latch, dispatch, result
// merge: load each outer entry, test it on later ones, refill a joined slot from the last entry, write back
// present: each stored rectangle is read from the store, then output once the output register is free
// one command at a time: a new beat is taken only in idle, after the previous command is done
// async reset clears count, flags, sequencer and config registers to defaults; the store is not cleared
`default_nettype none
module dirty_rect_tracker_unit #(
	parameter int MAX_RECTS = drt_pkg::DRT_MAX_RECTS,
	parameter int MAX_SIDE  = drt_pkg::DRT_MAX_SIDE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // rect_left, rect_top, rect_width, rect_height
	input  wire logic [2:0]  s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // out_left, out_top, out_width, out_height, stored_count,
	                                   // full_forced, zero fill
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast   // last
);
	import drt_pkg::*;

	ctrl_t   ctrl;
	status_t st;

	drt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.st       (st),
		.ctrl     (ctrl)
	);

	drt_datapath #(
		.MAX_RECTS (MAX_RECTS),
		.MAX_SIDE  (MAX_SIDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.ctrl      (ctrl),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.st        (st)
	);

	assign s_tready = ctrl.in_ready;

	a_non_rect_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_RECT) |-> m_tdata[51:0] == '0)
		else $error("non-rectangle result carries rectangle bits");

	a_rect_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_RECT) |-> m_tdata[58:52] == '0)
		else $error("presented rectangle reports uncleared count or flag");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.cnt <= DRT_CNT_W'(MAX_RECTS))
		else $error("stored count beyond store depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("beat taken while a command is in progress");

endmodule
`default_nettype wire

// ----- design/drt_datapath.sv -----
// rectangle store, clipping, merge unit, counters, config and result register
`default_nettype none
module drt_datapath #(
	parameter int MAX_RECTS = drt_pkg::DRT_MAX_RECTS,
	parameter int MAX_SIDE  = drt_pkg::DRT_MAX_SIDE
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [12:0]      cfg_data,
	input  wire logic [63:0]      s_tdata,
	input  wire logic [2:0]       s_tuser,
	input  wire drt_pkg::ctrl_t   ctrl,
	input  wire logic             m_tready,
	output logic                  m_tvalid,
	output logic [63:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast,
	output drt_pkg::status_t      st
);
	import drt_pkg::*;

	localparam int AW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNTW = $clog2(MAX_RECTS + 1);
	localparam int XW   = CNTW + 1;
	localparam int CW   = $clog2(MAX_SIDE + 1);
	localparam int EW   = 4 * CW;
	localparam int NW   = CW + 2;
	localparam int SW   = DRT_CLIP_W;
	localparam int OW   = DRT_OUT_W;

	logic [12:0] ww_q, wh_q;
	logic [7:0]  md_q;
	logic [5:0]  dl_q;
	logic [3:0]  mp_q;

	logic [2:0]        cmd_q;
	logic [15:0]       in_x_q, in_y_q, in_w_q, in_h_q;
	logic [CW-1:0]     cx_q, cy_q, cw_q, ch_q;
	logic              drop_q;
	logic [EW-1:0]     mem_q [MAX_RECTS];
	logic [EW-1:0]     rdata_q, a_q;
	logic [CNTW-1:0]   cnt_q, emit_n_q;
	logic              ff_q, dirty_q, joined_q;
	logic [3:0]        passes_q;
	logic [AW-1:0]     i_q, j_q, k_q;

	logic              out_valid_q, out_ff_q, out_last_q;
	kind_t             out_kind_q;
	logic [OW-1:0]     out_x_q, out_y_q, out_w_q, out_h_q;
	logic [5:0]        out_cnt_q;

	function automatic logic near_f(input logic [EW-1:0] a, input logic [EW-1:0] b,
		input logic [7:0] d);
		logic [NW-1:0] ax, ay, aw, ah, bx, by, bw, bh, dd;
		ax = NW'(a[CW-1:0]);
		ay = NW'(a[2*CW-1:CW]);
		aw = NW'(a[3*CW-1:2*CW]);
		ah = NW'(a[4*CW-1:3*CW]);
		bx = NW'(b[CW-1:0]);
		by = NW'(b[2*CW-1:CW]);
		bw = NW'(b[3*CW-1:2*CW]);
		bh = NW'(b[4*CW-1:3*CW]);
		dd = NW'(d);
		return (ax <= bx + bw + dd) && (ax + aw + dd >= bx) &&
			(ay <= by + bh + dd) && (ay + ah + dd >= by);
	endfunction

	function automatic logic [EW-1:0] join_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
		logic [CW:0] ax, ay, ae, af, bx, by, be, bf, x0, y0, x1, y1, wd, ht;
		ax = (CW+1)'(a[CW-1:0]);
		ay = (CW+1)'(a[2*CW-1:CW]);
		ae = ax + (CW+1)'(a[3*CW-1:2*CW]);
		af = ay + (CW+1)'(a[4*CW-1:3*CW]);
		bx = (CW+1)'(b[CW-1:0]);
		by = (CW+1)'(b[2*CW-1:CW]);
		be = bx + (CW+1)'(b[3*CW-1:2*CW]);
		bf = by + (CW+1)'(b[4*CW-1:3*CW]);
		x0 = (ax < bx) ? ax : bx;
		y0 = (ay < by) ? ay : by;
		x1 = (ae > be) ? ae : be;
		y1 = (af > bf) ? af : bf;
		wd = x1 - x0;
		ht = y1 - y0;
		return {ht[CW-1:0], wd[CW-1:0], y0[CW-1:0], x0[CW-1:0]};
	endfunction

	// clipping
	logic signed [SW-1:0] x18, y18, w18, h18, cx, cy, cw, ch, side_s, wwl, whl;
	logic                 drop;

	assign x18    = {{(SW-16){in_x_q[15]}}, in_x_q};
	assign y18    = {{(SW-16){in_y_q[15]}}, in_y_q};
	assign w18    = {{(SW-16){in_w_q[15]}}, in_w_q};
	assign h18    = {{(SW-16){in_h_q[15]}}, in_h_q};
	assign side_s = SW'(MAX_SIDE);
	assign wwl    = ($signed({{(SW-13){1'b0}}, ww_q}) > side_s) ? side_s :
		$signed({{(SW-13){1'b0}}, ww_q});
	assign whl    = ($signed({{(SW-13){1'b0}}, wh_q}) > side_s) ? side_s :
		$signed({{(SW-13){1'b0}}, wh_q});

	always_comb begin
		cx = x18[SW-1] ? '0 : x18;
		cy = y18[SW-1] ? '0 : y18;
		cw = w18 + (x18[SW-1] ? x18 : '0);
		ch = h18 + (y18[SW-1] ? y18 : '0);
		if (cx + cw > wwl) begin
			cw = wwl - cx;
		end
		if (cy + ch > whl) begin
			ch = whl - cy;
		end
	end

	assign drop = (cw <= 0) || (ch <= 0);

	// shared merge unit
	logic [EW-1:0] c_entry, near_a, join_now;
	logic          near_now;

	assign c_entry  = {ch_q, cw_q, cy_q, cx_q};
	assign near_a   = (ctrl.op == OP_ADD) ? c_entry : a_q;
	assign near_now = near_f(near_a, rdata_q, md_q);
	assign join_now = join_f(near_a, rdata_q);

	// status
	logic j_last, j_next_ok, i_more, k_last, out_free, cnt_nz, cnt_room;

	assign j_last    = (XW'(j_q) + XW'(1)) == XW'(cnt_q);
	assign j_next_ok = (XW'(j_q) + XW'(1)) < XW'(cnt_q);
	assign i_more    = (XW'(i_q) + XW'(2)) < XW'(cnt_q);
	assign k_last    = (XW'(k_q) + XW'(1)) == XW'(emit_n_q);
	assign out_free  = !out_valid_q || m_tready;
	assign cnt_nz    = cnt_q != '0;
	assign cnt_room  = cnt_q < CNTW'(MAX_RECTS);

	always_comb begin
		st.cmd        = cmd_t'(cmd_q);
		st.dirty      = dirty_q;
		st.cnt_le1    = cnt_q <= CNTW'(1);
		st.near       = near_now;
		st.j_last     = j_last;
		st.j_next_ok  = j_next_ok;
		st.i_more     = i_more;
		st.pass_again = joined_q && (cnt_q > CNTW'(1)) && (passes_q < mp_q);
		st.partial    = cnt_nz && (8'(cnt_q) <= 8'(dl_q)) && !ff_q;
		st.k_last     = k_last;
		st.out_free   = out_free;
		st.cnt        = DRT_CNT_W'(cnt_q);
	end

	// memory port control
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = c_entry;
		case (ctrl.op)
			OP_CLIP: begin
				re    = 1'b1;
				raddr = AW'(cnt_q - CNTW'(1));
			end
			OP_ADD: begin
				if (!drop_q) begin
					if (cnt_nz && near_now) begin
						we    = 1'b1;
						waddr = AW'(cnt_q - CNTW'(1));
						wdata = join_now;
					end else if (cnt_room) begin
						we    = 1'b1;
						waddr = AW'(cnt_q);
						wdata = c_entry;
					end
				end
			end
			OP_PASS: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_LDA: begin
				re    = 1'b1;
				raddr = AW'(i_q + AW'(1));
			end
			OP_CMP: begin
				if (near_now) begin
					if (!j_last) begin
						re    = 1'b1;
						raddr = AW'(cnt_q - CNTW'(1));
					end
				end else if (j_next_ok) begin
					re    = 1'b1;
					raddr = AW'(j_q + AW'(1));
				end
			end
			OP_MOVE: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = rdata_q;
			end
			OP_ENDI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = a_q;
				if (i_more) begin
					re    = 1'b1;
					raddr = AW'(i_q + AW'(1));
				end
			end
			OP_RDK: begin
				re    = 1'b1;
				raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= DRT_RST_WIDTH;
			wh_q <= DRT_RST_HEIGHT;
			md_q <= DRT_RST_DISTANCE;
			dl_q <= DRT_RST_LIMIT;
			mp_q <= DRT_RST_PASSES;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WINDOW_WIDTH:   ww_q <= cfg_data;
				REG_WINDOW_HEIGHT:  wh_q <= cfg_data;
				REG_MERGE_DISTANCE: md_q <= cfg_data[7:0];
				REG_DIRECT_LIMIT:   dl_q <= cfg_data[5:0];
				REG_MERGE_PASSES:   mp_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ff_q        <= 1'b0;
			dirty_q     <= 1'b0;
			joined_q    <= 1'b0;
			passes_q    <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_ADD: begin
					if (!drop_q && !(cnt_nz && near_now)) begin
						if (cnt_room) begin
							cnt_q <= cnt_q + CNTW'(1);
						end else begin
							ff_q <= 1'b1;
						end
					end
				end
				OP_DIRTY: dirty_q <= 1'b1;
				OP_BEGIN: begin
					cnt_q <= '0;
					ff_q  <= 1'b0;
				end
				OP_FORCE: ff_q <= 1'b1;
				OP_MINIT: passes_q <= '0;
				OP_PASS: begin
					i_q      <= '0;
					joined_q <= 1'b0;
					passes_q <= passes_q + 4'd1;
				end
				OP_LDA: j_q <= AW'(i_q + AW'(1));
				OP_CMP: begin
					if (near_now) begin
						cnt_q    <= cnt_q - CNTW'(1);
						joined_q <= 1'b1;
					end else begin
						j_q <= AW'(j_q + AW'(1));
					end
				end
				OP_ENDI: i_q <= AW'(i_q + AW'(1));
				OP_PRES: begin
					k_q     <= '0;
					dirty_q <= 1'b0;
					cnt_q   <= '0;
					ff_q    <= 1'b0;
				end
				OP_ORECT: k_q <= AW'(k_q + AW'(1));
				default: begin
				end
			endcase
			if (ctrl.op == OP_RESP || ctrl.op == OP_ORECT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LATCH: begin
				cmd_q  <= s_tuser;
				in_x_q <= s_tdata[15:0];
				in_y_q <= s_tdata[31:16];
				in_w_q <= s_tdata[47:32];
				in_h_q <= s_tdata[63:48];
			end
			OP_CLIP: begin
				cx_q   <= cx[CW-1:0];
				cy_q   <= cy[CW-1:0];
				cw_q   <= cw[CW-1:0];
				ch_q   <= ch[CW-1:0];
				drop_q <= drop;
			end
			OP_LDA: a_q <= rdata_q;
			OP_CMP: begin
				if (near_now) begin
					a_q <= join_now;
				end
			end
			OP_PRES: emit_n_q <= cnt_q;
			default: begin
			end
		endcase
		if (ctrl.op == OP_RESP) begin
			out_kind_q <= ctrl.kind;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_w_q    <= '0;
			out_h_q    <= '0;
			out_cnt_q  <= 6'(cnt_q);
			out_ff_q   <= ff_q;
			out_last_q <= 1'b1;
		end else if (ctrl.op == OP_ORECT) begin
			out_kind_q <= KIND_RECT;
			out_x_q    <= OW'(rdata_q[CW-1:0]);
			out_y_q    <= OW'(rdata_q[2*CW-1:CW]);
			out_w_q    <= OW'(rdata_q[3*CW-1:2*CW]);
			out_h_q    <= OW'(rdata_q[4*CW-1:3*CW]);
			out_cnt_q  <= 6'(cnt_q);
			out_ff_q   <= ff_q;
			out_last_q <= k_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_ff_q, out_cnt_q, out_h_q, out_w_q, out_y_q, out_x_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- design/drt_ctrl.sv -----
// command sequencer of the dirty rectangle tracker
`default_nettype none
module drt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire drt_pkg::status_t st,
	output drt_pkg::ctrl_t        ctrl
);
	import drt_pkg::*;

	state_t state_q, state_d;
	kind_t  resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			resp_q  <= KIND_ACK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		resp_d        = resp_q;
		ctrl.op       = OP_IDLE;
		ctrl.kind     = resp_q;
		ctrl.in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (s_tvalid) begin
					ctrl.op = OP_LATCH;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				resp_d  = KIND_ACK;
				state_d = ST_RESP;
				case (st.cmd)
					CMD_ADD: begin
						ctrl.op = OP_CLIP;
						state_d = ST_ADD;
					end
					CMD_DIRTY: ctrl.op = OP_DIRTY;
					CMD_BEGIN: ctrl.op = OP_BEGIN;
					CMD_FORCE: ctrl.op = OP_FORCE;
					CMD_MERGE: begin
						if (!st.cnt_le1) begin
							ctrl.op = OP_MINIT;
							state_d = ST_MPASS;
						end
					end
					CMD_PRESENT: begin
						if (!st.dirty) begin
							resp_d = KIND_NONE;
						end else begin
							ctrl.op = OP_PRES;
							if (st.partial) begin
								state_d = ST_PRD;
							end else begin
								resp_d = KIND_FULL;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_ADD: begin
				ctrl.op = OP_ADD;
				state_d = ST_RESP;
			end
			ST_MPASS: begin
				ctrl.op = OP_PASS;
				state_d = ST_MLDA;
			end
			ST_MLDA: begin
				ctrl.op = OP_LDA;
				state_d = ST_MCMP;
			end
			ST_MCMP: begin
				ctrl.op = OP_CMP;
				if (st.near) begin
					state_d = st.j_last ? ST_MENDI : ST_MMOVE;
				end else begin
					state_d = st.j_next_ok ? ST_MCMP : ST_MENDI;
				end
			end
			ST_MMOVE: begin
				ctrl.op = OP_MOVE;
				state_d = ST_MCMP;
			end
			ST_MENDI: begin
				ctrl.op = OP_ENDI;
				state_d = st.i_more ? ST_MLDA : ST_MPEND;
			end
			ST_MPEND: begin
				state_d = st.pass_again ? ST_MPASS : ST_RESP;
			end
			ST_PRD: begin
				ctrl.op = OP_RDK;
				state_d = ST_PRECT;
			end
			ST_PRECT: begin
				if (st.out_free) begin
					ctrl.op = OP_ORECT;
					state_d = st.k_last ? ST_IDLE : ST_PRD;
				end
			end
			ST_RESP: begin
				if (st.out_free) begin
					ctrl.op = OP_RESP;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire
